@@ sv/klk_pkg.sv @@
// ----------------------------------------------------------------------------
// klk_pkg: shared types and constants for the keypad code lock
// Key table, phase and event codes, decoded key and result word layouts.
// ----------------------------------------------------------------------------
package klk_pkg;

  localparam int CODE_LEN_DEF = 6;
  localparam int SCAN_W       = 8;
  localparam int SYM_W        = 4;
  localparam int MASTER_W     = 24;
  localparam int COUNT_W      = 3;

  localparam logic [MASTER_W-1:0] MASTER_RST = 24'h123456;

  localparam logic [SYM_W-1:0] SYM_ONE   = 4'd1;
  localparam logic [SYM_W-1:0] SYM_BACK  = 4'd14;
  localparam logic [SYM_W-1:0] SYM_ENTER = 4'd15;

  // Active-low row/column codes, indexed by key symbol.
  localparam logic [SCAN_W-1:0] KEY_CODES [16] = '{
    8'h77, 8'h7b, 8'h7d, 8'h7e, 8'hb7, 8'hbb, 8'hbd, 8'hbe,
    8'hd7, 8'hdb, 8'hdd, 8'hde, 8'he7, 8'heb, 8'hed, 8'hee
  };

  typedef enum logic [2:0] {
    PH_MODE, PH_ENTRY, PH_ASK, PH_NEW, PH_CONFIRM, PH_ALARM
  } phase_t;

  typedef enum logic [3:0] {
    EV_NONE, EV_ADDED, EV_REMOVED, EV_IGNORED, EV_MODE, EV_UNLOCKED,
    EV_ALARM, EV_DECLINED, EV_REKEY_OK, EV_REKEY_FAIL
  } event_t;

  typedef struct packed {
    logic             known;
    logic [SYM_W-1:0] sym;
  } key_dec_t;

  typedef struct packed {
    logic [SYM_W-1:0]   key_symbol;
    logic               key_known;
    logic [2:0]         phase;
    logic [COUNT_W-1:0] entry_count;
    logic [3:0]         event_res;
    logic               lock_open;
    logic               alarm;
  } res_t;

  // Unknown codes decode to symbol zero with known low.
  function automatic key_dec_t decode_key(logic [SCAN_W-1:0] code);
    key_dec_t d;
    d = '0;
    for (int i = 0; i < 16; i++) begin
      if (!d.known && code == KEY_CODES[i]) begin
        d.known = 1'b1;
        d.sym   = SYM_W'(i);
      end
    end
    return d;
  endfunction

endpackage

@@ sv/klk_ifs.sv @@
// ----------------------------------------------------------------------------
// klk_ifs: channel interfaces of the keypad code lock
// Scan code input, result output and master code write channels.
// ----------------------------------------------------------------------------
interface klk_in_if import klk_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [SCAN_W-1:0] scan_code;

  modport source (output valid, output scan_code, input ready);
  modport sink   (input valid, input scan_code, output ready);
endinterface

interface klk_out_if import klk_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [SYM_W-1:0]   key_symbol;
  logic               key_known;
  logic [2:0]         phase;
  logic [COUNT_W-1:0] entry_count;
  logic [3:0]         event_res;
  logic               lock_open;
  logic               alarm;

  modport source (output valid, output key_symbol, output key_known, output phase,
                  output entry_count, output event_res, output lock_open,
                  output alarm, input ready);
  modport sink   (input valid, input key_symbol, input key_known, input phase,
                  input entry_count, input event_res, input lock_open,
                  input alarm, output ready);
endinterface

interface klk_cfg_if import klk_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [MASTER_W-1:0] master_code;

  modport source (output valid, output master_code, input ready);
  modport sink   (input valid, input master_code, output ready);
endinterface

@@ sv/klk_in_stage.sv @@
// ----------------------------------------------------------------------------
// klk_in_stage: input register
// Holds one scan code word until the engine consumes it.
// ----------------------------------------------------------------------------
module klk_in_stage import klk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [SCAN_W-1:0] in_code,
  input  logic              adv,
  output logic              stg_vld,
  output logic [SCAN_W-1:0] stg_code
);

  logic              vld_r;
  logic [SCAN_W-1:0] code_r;

  // Take a new word when empty or when the held one leaves this cycle.
  assign in_ready = !vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (adv) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code_r <= in_code;
    end
  end

  assign stg_vld  = vld_r;
  assign stg_code = code_r;

endmodule

@@ sv/klk_engine.sv @@
// ----------------------------------------------------------------------------
// klk_engine: lock state and single-step update
// Decodes a key, advances the phase machine and entry buffer, builds the result.
// ----------------------------------------------------------------------------
module klk_engine import klk_pkg::*; #(
  parameter int CODE_LEN = CODE_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [SCAN_W-1:0]   scan_code,
  input  logic                cfg_we,
  input  logic [MASTER_W-1:0] cfg_data,
  output res_t                res
);

  localparam int CW = SYM_W * CODE_LEN;
  localparam int LW = $clog2(CODE_LEN + 1);
  localparam logic [LW-1:0] FULL = LW'(CODE_LEN);

  phase_t              phase_r, phase_nxt;
  logic [CW-1:0]       ent_r, ent_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  logic [CW-1:0]       first_r, first_nxt;
  logic                mmode_r, mmode_nxt;
  logic [CW-1:0]       user_r, user_nxt;
  logic                open_r, open_nxt;
  logic                alarm_r, alarm_nxt;
  logic [MASTER_W-1:0] master_r;

  key_dec_t      dec;
  logic          is_enter;
  logic          full;
  logic          chose_one;
  logic          match_cur;
  logic          confirm_ok;
  logic [CW-1:0] master_ext;
  event_t        ev;

  assign dec        = decode_key(scan_code);
  assign is_enter   = dec.known && phase_r != PH_ALARM && dec.sym == SYM_ENTER;
  assign full       = len_r == FULL;
  // Slot zero sits in the top nibble.
  assign chose_one  = len_r != '0 && ent_r[CW-1 -: SYM_W] == SYM_ONE;
  assign master_ext = CW'(master_r);
  assign match_cur  = full && ent_r == (mmode_r ? master_ext : user_r);
  assign confirm_ok = full && ent_r == first_r;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (is_enter) begin
      case (phase_r)
        PH_MODE:    phase_nxt = PH_ENTRY;
        PH_ENTRY:   phase_nxt = match_cur ? (mmode_r ? PH_MODE : PH_ASK) : PH_ALARM;
        PH_ASK:     phase_nxt = chose_one ? PH_NEW : PH_MODE;
        PH_NEW:     phase_nxt = full ? PH_CONFIRM : PH_MODE;
        PH_CONFIRM: phase_nxt = PH_MODE;
        default:    phase_nxt = phase_r;
      endcase
    end
  end

  // Buffer, flags and event.
  always_comb begin
    ent_nxt   = ent_r;
    len_nxt   = len_r;
    first_nxt = first_r;
    mmode_nxt = mmode_r;
    user_nxt  = user_r;
    open_nxt  = open_r;
    alarm_nxt = alarm_r;
    ev        = EV_NONE;
    if (dec.known) begin
      if (phase_r == PH_ALARM) begin
        ev = EV_IGNORED;
      end else if (dec.sym == SYM_ENTER) begin
        len_nxt = '0;
        case (phase_r)
          PH_MODE: begin
            mmode_nxt = chose_one;
            open_nxt  = 1'b0;
            ev        = EV_MODE;
          end
          PH_ENTRY: begin
            if (match_cur) begin
              open_nxt = 1'b1;
              ev       = EV_UNLOCKED;
            end else begin
              open_nxt  = 1'b0;
              alarm_nxt = 1'b1;
              ev        = EV_ALARM;
            end
          end
          PH_ASK: begin
            ev = chose_one ? EV_MODE : EV_DECLINED;
          end
          PH_NEW: begin
            if (full) begin
              first_nxt = ent_r;
              ev        = EV_NONE;
            end else begin
              ev = EV_REKEY_FAIL;
            end
          end
          PH_CONFIRM: begin
            if (confirm_ok) begin
              user_nxt = ent_r;
              ev       = EV_REKEY_OK;
            end else begin
              ev = EV_REKEY_FAIL;
            end
          end
          default: ev = EV_IGNORED;
        endcase
      end else if (dec.sym == SYM_BACK) begin
        if (len_r != '0) begin
          len_nxt = len_r - 1'b1;
          ev      = EV_REMOVED;
        end else begin
          ev = EV_IGNORED;
        end
      end else if (!full) begin
        for (int i = 0; i < CODE_LEN; i++) begin
          if (len_r == LW'(i)) begin
            ent_nxt[SYM_W*(CODE_LEN-1-i) +: SYM_W] = dec.sym;
          end
        end
        len_nxt = len_r + 1'b1;
        ev      = EV_ADDED;
      end else begin
        ev = EV_IGNORED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MODE;
      len_r   <= '0;
      mmode_r <= 1'b0;
      user_r  <= '0;
      open_r  <= 1'b0;
      alarm_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      mmode_r <= mmode_nxt;
      user_r  <= user_nxt;
      open_r  <= open_nxt;
      alarm_r <= alarm_nxt;
    end
  end

  // Symbol slots are read only after being written since the last enter.
  always_ff @(posedge clk) begin
    if (step) begin
      ent_r   <= ent_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= MASTER_RST;
    end else if (cfg_we) begin
      master_r <= cfg_data;
    end
  end

  assign res.key_symbol  = dec.sym;
  assign res.key_known   = dec.known;
  assign res.phase       = phase_nxt;
  assign res.entry_count = COUNT_W'(len_nxt);
  assign res.event_res   = ev;
  assign res.lock_open   = open_nxt;
  assign res.alarm       = alarm_nxt;

  a_alarm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_r |=> alarm_r) else $error("alarm flag dropped without reset");

  a_alarm_phase: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_r == (phase_r == PH_ALARM)) else $error("alarm flag and phase disagree");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= FULL) else $error("entry count beyond code length");

  a_open_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    !(open_r && alarm_r)) else $error("lock open while alarm raised");

endmodule

@@ sv/klk_out_stage.sv @@
// ----------------------------------------------------------------------------
// klk_out_stage: result register
// Holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module klk_out_stage import klk_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  res_t res,
  input  logic load,
  input  logic out_ready,
  output logic out_valid,
  output res_t res_r,
  output logic space
);

  logic vld_r;

  assign space     = !vld_r || out_ready;
  assign out_valid = vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  a_load_only_space: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vld_r) |-> $past(load)) else $error("result valid without a load");

endmodule

@@ sv/keypad_code_lock.sv @@
// ----------------------------------------------------------------------------
// keypad_code_lock: keypad code lock top level
// Decodes debounced 4x4 keypad scan codes and runs the code entry, unlock,
// alarm and rekey sequence, one result word per scan code word.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake          word
//   in_chan   in    valid / ready      scan_code[7:0]
//   out_chan  out   valid / ready      key_symbol, key_known, phase, entry_count,
//                                      event_res, lock_open, alarm
//   cfg_chan  in    valid / ready      master_code[23:0] (ready always high)
//
// An accepted word sits in the input register and passes through the lock
// update into the result register once the result register has room.
// Throughput is one word per cycle while the result channel does not stall;
// the lock state updates as a word moves into the result register, so the
// next word already sees it.
// A stalled result register holds the input register; both drain together.
// rst_n is synchronous: it returns to mode select, clears the user code and
// flags, and reloads the master code with its default.
// ----------------------------------------------------------------------------
module keypad_code_lock import klk_pkg::*; #(
  parameter int CODE_LEN = CODE_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  klk_in_if.sink    in_chan,
  klk_out_if.source out_chan,
  klk_cfg_if.sink   cfg_chan
);

  logic              stg_vld;
  logic [SCAN_W-1:0] stg_code;
  logic              space;
  logic              adv;
  res_t              res;
  res_t              res_r;

  // Advance a held scan code when the result register has room.
  assign adv = stg_vld && space;

  klk_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_code  (in_chan.scan_code),
    .adv      (adv),
    .stg_vld  (stg_vld),
    .stg_code (stg_code)
  );

  // Master code writes land directly; no stall on this channel.
  assign cfg_chan.ready = 1'b1;

  klk_engine #(
    .CODE_LEN (CODE_LEN)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .scan_code (stg_code),
    .cfg_we    (cfg_chan.valid),
    .cfg_data  (cfg_chan.master_code),
    .res       (res)
  );

  klk_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .load      (adv),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .res_r     (res_r),
    .space     (space)
  );

  // Unpack the result word onto the channel.
  assign out_chan.key_symbol  = res_r.key_symbol;
  assign out_chan.key_known   = res_r.key_known;
  assign out_chan.phase       = res_r.phase;
  assign out_chan.entry_count = res_r.entry_count;
  assign out_chan.event_res   = res_r.event_res;
  assign out_chan.lock_open   = res_r.lock_open;
  assign out_chan.alarm       = res_r.alarm;

endmodule

@@ tb/tb_keypad_code_lock.sv @@
// ----------------------------------------------------------------------------
// tb_keypad_code_lock: self-checking bench for the keypad code lock
// Drives scan code words through the input channel in random bursts while
// the result channel stalls on its own pattern. Each accepted scan word runs
// through a local model of the lock, and every result word is compared field
// by field with the oldest prediction. A directed table opens the run, random
// well-formed key sequences follow under several master codes, and the sticky
// alarm is provoked only at the very end since reset is applied just once.
// ----------------------------------------------------------------------------
module tb_keypad_code_lock;
  import klk_pkg::*;

  localparam int CODE_LEN = CODE_LEN_DEF;
  localparam int RANDOM_PER_CODE = 230;
  localparam logic [SCAN_W-1:0] SC_BACK  = KEY_CODES[SYM_BACK];
  localparam logic [SCAN_W-1:0] SC_ENTER = KEY_CODES[SYM_ENTER];

  // One row of the directed table: a scan word, and where the outcome is
  // obvious, the result word typed in by hand.
  typedef struct packed {
    logic [SCAN_W-1:0] scan;
    logic              typed;
    res_t              want;
  } row_t;

  logic clk;
  logic rst_n;

  klk_in_if  in_chan  ();
  klk_out_if out_chan ();
  klk_cfg_if cfg_chan ();

  keypad_code_lock uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Local copy of the lock state, advanced once per accepted scan word.
  phase_t             lock_phase = PH_MODE;
  logic [SYM_W-1:0]   held_syms [CODE_LEN] = '{default: '0};
  int unsigned        held_len = 0;
  logic [MASTER_W-1:0] pending_code = '0;
  logic [MASTER_W-1:0] user_code = '0;
  logic [MASTER_W-1:0] master_code = MASTER_RST;
  bit                 master_sel = 1'b0;
  bit                 open_now = 1'b0;
  bit                 alarm_now = 1'b0;

  // Result words predicted but not yet seen on the output channel.
  res_t lock_results_due [$];

  int mismatches = 0;
  int sent_count = 0;
  int live_count = 0;
  int burst_left = 0;
  int master_writes = 0;
  int unlocks = 0;
  int rekeys_ok = 0;
  int rekeys_refused = 0;

  // Opening table, starting from reset: master 123456, user code all zeros.
  row_t opening_rows [] = '{
    '{8'h00,        1'b1, res_t'{4'd0,  1'b0, PH_MODE,  3'd0, EV_NONE,       1'b0, 1'b0}},
    '{8'hff,        1'b1, res_t'{4'd0,  1'b0, PH_MODE,  3'd0, EV_NONE,       1'b0, 1'b0}},
    '{SC_BACK,      1'b1, res_t'{4'd14, 1'b1, PH_MODE,  3'd0, EV_IGNORED,    1'b0, 1'b0}},
    '{SC_ENTER,     1'b1, res_t'{4'd15, 1'b1, PH_ENTRY, 3'd0, EV_MODE,       1'b0, 1'b0}},
    '{KEY_CODES[0], 1'b1, res_t'{4'd0,  1'b1, PH_ENTRY, 3'd1, EV_ADDED,      1'b0, 1'b0}},
    '{KEY_CODES[0], 1'b0, '0},
    '{KEY_CODES[0], 1'b0, '0},
    '{KEY_CODES[0], 1'b0, '0},
    '{KEY_CODES[0], 1'b0, '0},
    '{KEY_CODES[0], 1'b0, '0},
    '{KEY_CODES[13], 1'b1, res_t'{4'd13, 1'b1, PH_ENTRY, 3'd6, EV_IGNORED,   1'b0, 1'b0}},
    '{SC_ENTER,     1'b1, res_t'{4'd15, 1'b1, PH_ASK,   3'd0, EV_UNLOCKED,   1'b1, 1'b0}},
    '{KEY_CODES[1], 1'b0, '0},
    '{SC_ENTER,     1'b1, res_t'{4'd15, 1'b1, PH_NEW,   3'd0, EV_MODE,       1'b1, 1'b0}},
    '{KEY_CODES[13], 1'b0, '0},
    '{SC_ENTER,     1'b1, res_t'{4'd15, 1'b1, PH_MODE,  3'd0, EV_REKEY_FAIL, 1'b1, 1'b0}},
    '{KEY_CODES[1], 1'b0, '0},
    '{SC_ENTER,     1'b1, res_t'{4'd15, 1'b1, PH_ENTRY, 3'd0, EV_MODE,       1'b0, 1'b0}},
    '{KEY_CODES[1], 1'b0, '0},
    '{KEY_CODES[2], 1'b0, '0},
    '{KEY_CODES[3], 1'b0, '0},
    '{KEY_CODES[4], 1'b0, '0},
    '{KEY_CODES[5], 1'b0, '0},
    '{KEY_CODES[9], 1'b0, '0},
    '{SC_BACK,      1'b0, '0},
    '{KEY_CODES[6], 1'b0, '0},
    '{SC_ENTER,     1'b0, '0}
  };

  // Closing table, entered from mode select with an empty buffer: a short
  // user code trips the alarm, after which every key is ignored.
  row_t alarm_rows [] = '{
    '{SC_ENTER,     1'b1, res_t'{4'd15, 1'b1, PH_ENTRY, 3'd0, EV_MODE,       1'b0, 1'b0}},
    '{KEY_CODES[5], 1'b0, '0},
    '{SC_ENTER,     1'b1, res_t'{4'd15, 1'b1, PH_ALARM, 3'd0, EV_ALARM,      1'b0, 1'b1}},
    '{KEY_CODES[3], 1'b1, res_t'{4'd3,  1'b1, PH_ALARM, 3'd0, EV_IGNORED,    1'b0, 1'b1}},
    '{SC_BACK,      1'b1, res_t'{4'd14, 1'b1, PH_ALARM, 3'd0, EV_IGNORED,    1'b0, 1'b1}},
    '{SC_ENTER,     1'b1, res_t'{4'd15, 1'b1, PH_ALARM, 3'd0, EV_IGNORED,    1'b0, 1'b1}},
    '{8'h00,        1'b1, res_t'{4'd0,  1'b0, PH_ALARM, 3'd0, EV_NONE,       1'b0, 1'b1}}
  };

  // Map a scan code to its key; unknown codes give symbol zero.
  function automatic bit key_lookup(input logic [SCAN_W-1:0] scan,
                                    output logic [SYM_W-1:0] sym);
    sym = '0;
    for (int k = 15; k >= 0; k--) begin
      if (KEY_CODES[k] == scan) begin
        sym = SYM_W'(k);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advance the local lock by one scan word and return the result word.
  function automatic res_t lock_step(input logic [SCAN_W-1:0] scan);
    res_t                r;
    logic [SYM_W-1:0]    sym;
    logic [MASTER_W-1:0] held_word;
    logic [MASTER_W-1:0] target;
    bit                  known;
    bit                  pick_one;
    event_t              ev;
    known = key_lookup(scan, sym);
    ev = EV_NONE;
    held_word = '0;
    for (int i = 0; i < CODE_LEN; i++) held_word = {held_word[MASTER_W-SYM_W-1:0], held_syms[i]};
    if (known) begin
      if (lock_phase == PH_ALARM) begin
        ev = EV_IGNORED;
      end else if (sym == SYM_ENTER) begin
        // An empty buffer at a choice counts as "not one".
        pick_one = held_len != 0 && held_syms[0] == SYM_ONE;
        case (lock_phase)
          PH_MODE: begin
            master_sel = pick_one;
            open_now = 1'b0;
            lock_phase = PH_ENTRY;
            ev = EV_MODE;
          end
          PH_ENTRY: begin
            target = master_sel ? master_code : user_code;
            // A match needs a full buffer; any miss is a wrong code.
            if (held_len == CODE_LEN && held_word == target) begin
              open_now = 1'b1;
              lock_phase = master_sel ? PH_MODE : PH_ASK;
              ev = EV_UNLOCKED;
            end else begin
              open_now = 1'b0;
              alarm_now = 1'b1;
              lock_phase = PH_ALARM;
              ev = EV_ALARM;
            end
          end
          PH_ASK: begin
            lock_phase = pick_one ? PH_NEW : PH_MODE;
            ev = pick_one ? EV_MODE : EV_DECLINED;
          end
          PH_NEW: begin
            if (held_len == CODE_LEN) begin
              pending_code = held_word;
              lock_phase = PH_CONFIRM;
            end else begin
              lock_phase = PH_MODE;
              ev = EV_REKEY_FAIL;
            end
          end
          default: begin
            if (held_len == CODE_LEN && held_word == pending_code) begin
              user_code = held_word;
              ev = EV_REKEY_OK;
            end else begin
              ev = EV_REKEY_FAIL;
            end
            lock_phase = PH_MODE;
          end
        endcase
        held_len = 0;
      end else if (sym == SYM_BACK) begin
        if (held_len > 0) begin
          held_len--;
          ev = EV_REMOVED;
        end else begin
          ev = EV_IGNORED;
        end
      end else if (held_len < CODE_LEN) begin
        held_syms[held_len] = sym;
        held_len++;
        ev = EV_ADDED;
      end else begin
        ev = EV_IGNORED;
      end
    end
    r.key_symbol  = sym;
    r.key_known   = known;
    r.phase       = lock_phase;
    r.entry_count = COUNT_W'(held_len);
    r.event_res   = ev;
    r.lock_open   = open_now;
    r.alarm       = alarm_now;
    return r;
  endfunction

  // Six random symbols that can actually be typed (no backspace, no enter).
  function automatic logic [MASTER_W-1:0] rand_typable();
    logic [MASTER_W-1:0] w;
    w = '0;
    for (int i = 0; i < CODE_LEN; i++) w = {w[MASTER_W-SYM_W-1:0], SYM_W'($urandom_range(0, 13))};
    return w;
  endfunction

  function automatic logic [SCAN_W-1:0] unknown_scan();
    logic [SCAN_W-1:0] scan;
    logic [SYM_W-1:0]  unused_sym;
    do scan = SCAN_W'($urandom_range(0, 255));
    while (key_lookup(scan, unused_sym));
    return scan;
  endfunction

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Send one scan word. Open a random gap between bursts, except in stretches
  // where the sender runs flat out. Hold valid high across back-to-back words.
  task automatic press(input logic [SCAN_W-1:0] scan, input bit typed = 1'b0,
                       input res_t want = '0);
    res_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ((sent_count / 150) % 3 != 0) begin
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid     <= 1'b1;
    in_chan.scan_code <= scan;
    do @(posedge clk);
    while (!in_chan.ready);
    predicted = lock_step(scan);
    lock_results_due.push_back(typed ? want : predicted);
    sent_count++;
    // Count only words the lock acts on; ignored keys and noise do not advance.
    if (predicted.key_known && predicted.event_res != EV_IGNORED) live_count++;
    case (predicted.event_res)
      EV_UNLOCKED:   unlocks++;
      EV_REKEY_OK:   rekeys_ok++;
      EV_REKEY_FAIL: rekeys_refused++;
      default: ;
    endcase
  endtask

  task automatic play_rows(input row_t rows []);
    foreach (rows[i]) press(rows[i].scan, rows[i].typed, rows[i].want);
  endtask

  // Type the first n symbols of a code, sprinkled with noise that leaves the
  // buffer as intended, then press enter.
  task automatic key_in_code(input logic [MASTER_W-1:0] code, input int n);
    logic [SYM_W-1:0] s;
    for (int i = 0; i < n; i++) begin
      s = code[MASTER_W-1-SYM_W*i -: SYM_W];
      if ($urandom_range(0, 9) == 0) press(unknown_scan());
      if ($urandom_range(0, 9) == 0) begin
        press(KEY_CODES[$urandom_range(0, 13)]);
        press(SC_BACK);
      end
      press(KEY_CODES[s]);
    end
    // Overflow a full buffer, or backspace an empty one, now and then.
    if (n == CODE_LEN && $urandom_range(0, 5) == 0) press(KEY_CODES[$urandom_range(0, 13)]);
    if (n == 0 && $urandom_range(0, 1) == 0) press(SC_BACK);
    press(SC_ENTER);
  endtask

  // Play one well-formed key sequence for the current phase. Code entry
  // always gets the right code so the lock never trips the alarm here.
  task automatic run_sequence();
    logic [MASTER_W-1:0] w;
    bit                  typable;
    w = rand_typable();
    typable = 1'b1;
    for (int i = 0; i < CODE_LEN; i++)
      if (master_code[SYM_W*i +: SYM_W] > 4'd13) typable = 1'b0;
    case (lock_phase)
      PH_MODE, PH_ASK: begin
        // Avoid master mode when its code holds a key that cannot be typed.
        if ((lock_phase == PH_ASK || typable) && $urandom_range(0, 1) == 1) begin
          w[MASTER_W-1 -: SYM_W] = SYM_ONE;
          key_in_code(w, $urandom_range(1, CODE_LEN));
        end else begin
          if (w[MASTER_W-1 -: SYM_W] == SYM_ONE) w[MASTER_W-1 -: SYM_W] = '0;
          key_in_code(w, $urandom_range(0, CODE_LEN));
        end
      end
      PH_ENTRY:   key_in_code(master_sel ? master_code : user_code, CODE_LEN);
      PH_NEW:     key_in_code(w, $urandom_range(0, 4) != 0 ? CODE_LEN
                                                           : $urandom_range(0, CODE_LEN - 1));
      PH_CONFIRM: begin
        if ($urandom_range(0, 3) != 0) key_in_code(pending_code, CODE_LEN);
        else key_in_code(w, $urandom_range(0, CODE_LEN));
      end
      default:    press(SCAN_W'($urandom_range(0, 255)));
    endcase
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (lock_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_master(input logic [MASTER_W-1:0] code);
    drain();
    cfg_chan.valid       <= 1'b1;
    cfg_chan.master_code <= code;
    do @(posedge clk);
    while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    master_code = code;
    master_writes++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: cycle through always ready, random stalls, a fixed comb and
  // long stall stretches.
  initial begin
    int unsigned rx_cycle;
    int          stall_left;
    rx_cycle = 0;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      case (rx_cycle[9:8])
        2'd0: out_chan.ready <= 1'b1;
        2'd1: out_chan.ready <= $urandom_range(0, 3) != 0;
        2'd2: out_chan.ready <= rx_cycle[2:0] != 3'd0 && rx_cycle[2:0] != 3'd3;
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_chan.ready <= 1'b0;
          end else begin
            out_chan.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (lock_results_due.size() == 0) begin
        $error("result word with no scan word pending");
        mismatches++;
      end else begin
        want = lock_results_due.pop_front();
        check_field("key_symbol", want.key_symbol, out_chan.key_symbol);
        check_field("key_known", 4'(want.key_known), 4'(out_chan.key_known));
        check_field("phase", 4'(want.phase), 4'(out_chan.phase));
        check_field("entry_count", 4'(want.entry_count), 4'(out_chan.entry_count));
        check_field("event_res", want.event_res, out_chan.event_res);
        check_field("lock_open", 4'(want.lock_open), 4'(out_chan.lock_open));
        check_field("alarm", 4'(want.alarm), 4'(out_chan.alarm));
      end
    end
  end

  initial begin
    logic [MASTER_W-1:0] master_plan [5];
    int                  goal;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.scan_code = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.master_code = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening runs on the reset master code.
    play_rows(opening_rows);

    // Random sessions under both extremes, the largest typable code and two
    // random ones, the last of which may hold untypable keys.
    master_plan = '{24'h000000, rand_typable(), 24'hffffff, 24'hdddddd,
                    MASTER_W'($urandom_range(0, 24'hffffff))};
    foreach (master_plan[p]) begin
      write_master(master_plan[p]);
      goal = live_count + RANDOM_PER_CODE;
      while (live_count < goal || lock_phase != PH_MODE) run_sequence();
    end

    // Trip the alarm last, then hammer the dead lock with random bytes.
    play_rows(alarm_rows);
    repeat (40) press(SCAN_W'($urandom_range(0, 255)));

    drain();
    repeat (8) @(posedge clk);
    $display("run covered %0d scan words (%0d acted on) under %0d master code writes",
             sent_count, live_count, master_writes);
    $display("lock opened %0d times, %0d rekeys taken, %0d rekeys refused, alarm at the end",
             unlocks, rekeys_ok, rekeys_refused);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

endmodule
